// ===== rtl/core/bdh_pkg.sv =====
// ---------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants for the button debounce and hold detector.
// ---------------------------------------------------------------------------
package bdh_pkg;

    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam int unsigned CFG_INDEX_BITS = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_HOLD = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_HOLD  = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIN_INVERT = 8'd3;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0] SHORT_HOLD_RESET = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] LONG_HOLD_RESET  = 16'd3000;
    localparam logic                     PIN_INVERT_RESET = 1'b1;

    // Event codes
    localparam logic [1:0] EV_PRESSED  = 2'd0;
    localparam logic [1:0] EV_RELEASED = 2'd1;
    localparam logic [1:0] EV_SHORT    = 2'd2;
    localparam logic [1:0] EV_LONG     = 2'd3;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] debounce_ticks;
        logic [CFG_DATA_BITS-1:0] short_hold_ticks;
        logic [CFG_DATA_BITS-1:0] long_hold_ticks;
        logic                     pin_invert;
    } bdh_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } bdh_event_t;

endpackage

// ===== rtl/core/bdh_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// bdh_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ---------------------------------------------------------------------------
module bdh_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdh_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bdh_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output bdh_pkg::bdh_cfg_t                    cfg
);

    bdh_pkg::bdh_cfg_t cfg_reg;
    bdh_pkg::bdh_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the index; an unknown index leaves everything unchanged
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bdh_pkg::REG_DEBOUNCE:   cfg_next.debounce_ticks   = cfg_data;
                bdh_pkg::REG_SHORT_HOLD: cfg_next.short_hold_ticks = cfg_data;
                bdh_pkg::REG_LONG_HOLD:  cfg_next.long_hold_ticks  = cfg_data;
                bdh_pkg::REG_PIN_INVERT: cfg_next.pin_invert       = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= bdh_pkg::DEBOUNCE_RESET;
            cfg_reg.short_hold_ticks <= bdh_pkg::SHORT_HOLD_RESET;
            cfg_reg.long_hold_ticks  <= bdh_pkg::LONG_HOLD_RESET;
            cfg_reg.pin_invert       <= bdh_pkg::PIN_INVERT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/bdh_tracker.sv =====
// ---------------------------------------------------------------------------
// bdh_tracker
// Debounce and hold state; advances by one tick per enabled cycle.
// ---------------------------------------------------------------------------
module bdh_tracker
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 pin_level,
    input  bdh_pkg::bdh_cfg_t    cfg,
    output bdh_pkg::bdh_event_t  event_out
);

    localparam int unsigned CMP_BITS =
        (COUNT_BITS > bdh_pkg::CFG_DATA_BITS) ? COUNT_BITS : bdh_pkg::CFG_DATA_BITS;

    logic                  raw_reg, raw_next;
    logic                  stable_reg, stable_next;
    logic [COUNT_BITS-1:0] quiet_reg, quiet_next;
    logic [COUNT_BITS-1:0] held_reg, held_next;
    logic                  short_done_reg, short_done_next;
    logic                  long_done_reg, long_done_next;

    logic                  pressed;
    logic [COUNT_BITS-1:0] held_inc;
    logic [CMP_BITS-1:0]   quiet_cmp;
    logic [CMP_BITS-1:0]   held_cmp;
    logic [CMP_BITS-1:0]   deb_cmp;
    logic [CMP_BITS-1:0]   short_cmp;
    logic [CMP_BITS-1:0]   long_cmp;

    always_comb
    begin
        pressed    = cfg.pin_invert ? ~pin_level : pin_level;
        raw_next   = pressed;
        // Restart the quiet count on a change, else count up and saturate
        if (pressed != raw_reg)
            quiet_next = '0;
        else if (&quiet_reg)
            quiet_next = quiet_reg;
        else
            quiet_next = quiet_reg + 1'b1;

        if (stable_reg && !(&held_reg))
            held_inc = held_reg + 1'b1;
        else
            held_inc = held_reg;

        quiet_cmp = CMP_BITS'(quiet_next);
        held_cmp  = CMP_BITS'(held_inc);
        deb_cmp   = CMP_BITS'(cfg.debounce_ticks);
        short_cmp = CMP_BITS'(cfg.short_hold_ticks);
        long_cmp  = CMP_BITS'(cfg.long_hold_ticks);

        stable_next     = stable_reg;
        held_next       = held_inc;
        short_done_next = short_done_reg;
        long_done_next  = long_done_reg;
        event_out.valid = 1'b0;
        event_out.code  = bdh_pkg::EV_PRESSED;

        if (raw_next != stable_reg)
        begin
            if (quiet_cmp >= deb_cmp)
            begin
                stable_next     = raw_next;
                held_next       = '0;
                short_done_next = 1'b0;
                long_done_next  = 1'b0;
                event_out.valid = 1'b1;
                event_out.code  = raw_next ? bdh_pkg::EV_PRESSED : bdh_pkg::EV_RELEASED;
            end
        end
        else if (stable_reg)
        begin
            if (!long_done_reg && (long_cmp != '0) && (held_cmp >= long_cmp))
            begin
                long_done_next  = 1'b1;
                short_done_next = 1'b1;
                event_out.valid = 1'b1;
                event_out.code  = bdh_pkg::EV_LONG;
            end
            else if (!short_done_reg && (short_cmp != '0) && (held_cmp >= short_cmp))
            begin
                short_done_next = 1'b1;
                event_out.valid = 1'b1;
                event_out.code  = bdh_pkg::EV_SHORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            quiet_reg      <= '0;
            held_reg       <= '0;
            short_done_reg <= 1'b0;
            long_done_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            raw_reg        <= raw_next;
            stable_reg     <= stable_next;
            quiet_reg      <= quiet_next;
            held_reg       <= held_next;
            short_done_reg <= short_done_next;
            long_done_reg  <= long_done_next;
        end
    end

endmodule

// ===== rtl/core/button_debounce_hold_detector.sv =====
// ---------------------------------------------------------------------------
// button_debounce_hold_detector
// Debounces a sampled button pin and reports press, release, short and
// long hold events.
// ---------------------------------------------------------------------------
// Usage:
//   Feed one word per one-millisecond tick on the input channel
//   (in_valid/in_ready, pin_level). Each word may cause zero or one event
//   word on the output channel (out_valid/out_ready, event_code):
//   pressed, released, short hold or long hold.
//   Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
//   debounce time, both hold thresholds and the pin polarity; write them
//   only while the block is idle. cfg_ready is always high.
//   Path: an event word passes through the input register, then the state
//   step into the output register; a stall on the output channel can hold
//   its tick word in the input register in between.
//   Throughput: one word per cycle while the receiver takes every event;
//   a stall on the output channel holds the input.
//   Reset clears all state and loads the register defaults (debounce 50,
//   short hold 1000, long hold 3000, low pin level read as pressed).
//   When the receiver stalls, the event is held in the output register
//   and the input register stops; in_ready drops only while both are full.
// ---------------------------------------------------------------------------
module button_debounce_hold_detector
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input tick channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                pin_level,
    // event channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          event_code,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bdh_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    bdh_pkg::bdh_cfg_t   cfg;
    bdh_pkg::bdh_event_t step_event;

    // Input register: one tick word waiting for the tracker
    logic       in_valid_reg;
    logic       pin_reg;
    // Output register: one event word waiting for the receiver
    logic       out_valid_reg;
    logic [1:0] code_reg;

    logic       out_free;
    logic       step_en;

    // The output register can take a new event when empty or draining now
    assign out_free = !out_valid_reg || out_ready;
    // Advance the tracker by one tick whenever the held word can move on
    assign step_en  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    assign out_valid  = out_valid_reg;
    assign event_code = code_reg;

    bdh_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdh_tracker
    #(
        .COUNT_BITS (COUNT_BITS)
    )
    u_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .pin_level (pin_reg),
        .cfg       (cfg),
        .event_out (step_event)
    );

    // Capture a tick word; drop the held one once the tracker has used it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_reg <= pin_level;
        end
    end

    // Load an event when the tracker produces one, hold it while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step_en && step_event.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && step_event.valid)
        begin
            code_reg <= step_event.code;
        end
    end

endmodule

// ===== rtl/core/bdh_checker.sv =====
// ---------------------------------------------------------------------------
// bdh_checker
// Port-level checks on the debounce and hold detector, bound to the top.
// ---------------------------------------------------------------------------
module bdh_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] event_code
);

    // A stalled event holds its code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code))
        else $error("event word changed while stalled");

    // A receiver that takes words never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    // The input only stalls behind a waiting event
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output register");

    // A fresh event follows an accepted input word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("event word without a matching tick word");

endmodule

bind button_debounce_hold_detector bdh_checker u_bdh_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_code (event_code)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce and hold detector. A short
// table of directed ticks and register writes comes first. Randomised
// phases of clean presses, bounces and pin noise follow, each under fresh
// register settings. Event words are checked against a local debounce
// and hold tracker or the table. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CNT_W        = 16;
    localparam int          IDX_W        = bdh_pkg::CFG_INDEX_BITS;
    localparam int          DATA_W       = bdh_pkg::CFG_DATA_BITS;
    localparam int          NUM_REGS     = 4;
    localparam int          RANDOM_TICKS = 1250;
    localparam int          CALM_TICKS   = 150;   // final stretch with no idling
    localparam int          HOLD_OFF     = 4;     // pipeline depth plus margin
    localparam int          STALL_LIMIT  = 2000;  // cycles with no word moving

    // How a directed tick is checked: by the tracker, or by a value typed
    // into the table (no event, or one given event).
    typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_EVENT} chk_t;

    typedef struct packed {
        logic              is_reg;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic              pin;
        chk_t              chk;
        logic [1:0]        code;
    } stim_row_t;

    // Debounce and hold state as the tracker keeps it
    typedef struct packed {
        logic             raw;
        logic             stable;
        logic [CNT_W-1:0] quiet;
        logic [CNT_W-1:0] held;
        logic             short_fired;
        logic             long_fired;
    } button_state_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              pin_level;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        event_code;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;

    bdh_pkg::bdh_cfg_t shadow_cfg;
    button_state_t     button;
    logic [1:0]        pending_events[$];
    logic [1:0]        oldest_event;
    stim_row_t         script[$];

    int errors     = 0;
    int gap_pct    = 15;
    int stall_pct  = 15;
    int stall_left = 0;
    int idle_run   = 0;
    bit calm       = 1'b0;

    button_debounce_hold_detector #(
        .COUNT_BITS (CNT_W)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pin_level  (pin_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Tracker: advance the debounce and hold state by one tick
    // -----------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Returns 1 when the tick raises an event, with its code in code.
    function automatic bit debounce_tick(input logic pin, output logic [1:0] code);
        logic now_pressed;
        code = bdh_pkg::EV_PRESSED;
        now_pressed = shadow_cfg.pin_invert ? ~pin : pin;

        // Any change of the raw level restarts the quiet count
        if (now_pressed != button.raw)
        begin
            button.raw   = now_pressed;
            button.quiet = '0;
        end
        else
            button.quiet = sat_inc(button.quiet);

        if (button.stable)
            button.held = sat_inc(button.held);

        // Edge: stable follows raw once it has been quiet long enough
        if (button.raw != button.stable)
        begin
            if (button.quiet < shadow_cfg.debounce_ticks)
                return 1'b0;
            button.stable      = button.raw;
            button.held        = '0;
            button.short_fired = 1'b0;
            button.long_fired  = 1'b0;
            code = button.stable ? bdh_pkg::EV_PRESSED : bdh_pkg::EV_RELEASED;
            return 1'b1;
        end

        if (!button.stable)
            return 1'b0;

        // Long hold is checked first and also retires the short hold
        if (!button.long_fired && shadow_cfg.long_hold_ticks != '0 &&
            button.held >= shadow_cfg.long_hold_ticks)
        begin
            button.long_fired  = 1'b1;
            button.short_fired = 1'b1;
            code = bdh_pkg::EV_LONG;
            return 1'b1;
        end

        if (!button.short_fired && shadow_cfg.short_hold_ticks != '0 &&
            button.held >= shadow_cfg.short_hold_ticks)
        begin
            button.short_fired = 1'b1;
            code = bdh_pkg::EV_SHORT;
            return 1'b1;
        end

        return 1'b0;
    endfunction

    // -----------------------------------------------------------------------
    // Table rows
    // -----------------------------------------------------------------------
    function automatic stim_row_t tick_row(input logic pin, input chk_t chk,
                                           input logic [1:0] code);
        return '{is_reg: 1'b0, idx: '0, data: '0, pin: pin, chk: chk, code: code};
    endfunction

    function automatic stim_row_t reg_row(input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] data);
        return '{is_reg: 1'b1, idx: idx, data: data, pin: 1'b0, chk: CHK_MODEL,
                 code: bdh_pkg::EV_PRESSED};
    endfunction

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------
    // Offer one tick word, hold it until taken, then record what it should
    // raise. Valid stays high into the next word unless a gap is drawn.
    task automatic send_tick(input logic pin, input chk_t chk, input logic [1:0] code);
        logic [1:0] model_code;
        bit         fired;
        in_valid  <= 1'b1;
        pin_level <= pin;
        do
            @(posedge clk);
        while (!in_ready);

        fired = debounce_tick(pin, model_code);
        case (chk)
            CHK_MODEL: if (fired) pending_events.push_back(model_code);
            CHK_EVENT: pending_events.push_back(code);
            default:   ;
        endcase

        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Write one register. Drain every outstanding event first, then let the
    // pipeline settle, since a tick that raises nothing may still be in it.
    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);

        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;

        case (idx)
            bdh_pkg::REG_DEBOUNCE:   shadow_cfg.debounce_ticks   = data;
            bdh_pkg::REG_SHORT_HOLD: shadow_cfg.short_hold_ticks = data;
            bdh_pkg::REG_LONG_HOLD:  shadow_cfg.long_hold_ticks  = data;
            bdh_pkg::REG_PIN_INVERT: shadow_cfg.pin_invert       = data[0];
            default:                 ;   // unknown index: dropped by the block
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Receiver side: stall in random bursts, none in the calm tail
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!calm && stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 12);
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Event checker: compare each event word with the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event_code: expected none, actual %0d", event_code);
                errors = errors + 1;
            end
            else
            begin
                oldest_event = pending_events.pop_front();
                if (event_code !== oldest_event)
                begin
                    $error("event_code: expected %0d, actual %0d", oldest_event, event_code);
                    errors = errors + 1;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run if no word moves on any channel for too long
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_run = 0;
        else
            idle_run = idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("FAIL button_debounce_hold_detector");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        int  random_ticks;
        int  phase;
        int  deb;
        int  span;
        int  run;
        bit  noisy;
        bit  extreme;
        bit  level;
        logic [DATA_W-1:0] short_val;
        logic [DATA_W-1:0] long_val;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        pin_level <= 1'b0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        shadow_cfg = '{debounce_ticks:   bdh_pkg::DEBOUNCE_RESET,
                       short_hold_ticks: bdh_pkg::SHORT_HOLD_RESET,
                       long_hold_ticks:  bdh_pkg::LONG_HOLD_RESET,
                       pin_invert:       bdh_pkg::PIN_INVERT_RESET};
        button = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: low level pressed, debounce of 50, so nothing moves
        script.push_back(tick_row(1'b1, CHK_QUIET, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_QUIET, bdh_pkg::EV_PRESSED));
        // Zero debounce: stable follows on the next quiet tick
        script.push_back(reg_row(bdh_pkg::REG_DEBOUNCE, 16'd0));
        script.push_back(tick_row(1'b0, CHK_EVENT, bdh_pkg::EV_PRESSED));
        // Short hold at 2, long hold at 4
        script.push_back(reg_row(bdh_pkg::REG_SHORT_HOLD, 16'd2));
        script.push_back(reg_row(bdh_pkg::REG_LONG_HOLD, 16'd4));
        script.push_back(tick_row(1'b0, CHK_QUIET, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_EVENT, bdh_pkg::EV_SHORT));
        script.push_back(tick_row(1'b0, CHK_QUIET, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_EVENT, bdh_pkg::EV_LONG));
        script.push_back(tick_row(1'b1, CHK_EVENT, bdh_pkg::EV_RELEASED));
        // Long not above short: long fires, short is then never seen
        script.push_back(reg_row(bdh_pkg::REG_SHORT_HOLD, 16'd3));
        script.push_back(reg_row(bdh_pkg::REG_LONG_HOLD, 16'd2));
        script.push_back(tick_row(1'b0, CHK_EVENT, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_QUIET, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_EVENT, bdh_pkg::EV_LONG));
        script.push_back(tick_row(1'b0, CHK_QUIET, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b1, CHK_EVENT, bdh_pkg::EV_RELEASED));
        // Debounce of 2, then a bounce while held
        script.push_back(reg_row(bdh_pkg::REG_DEBOUNCE, 16'd2));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b1, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b1, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));
        // Flip polarity while pressed, then release through the debounce
        script.push_back(reg_row(bdh_pkg::REG_PIN_INVERT, 16'd0));
        script.push_back(tick_row(1'b1, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));
        // Both hold events disabled
        script.push_back(reg_row(bdh_pkg::REG_SHORT_HOLD, 16'd0));
        script.push_back(reg_row(bdh_pkg::REG_LONG_HOLD, 16'd0));
        script.push_back(reg_row(bdh_pkg::REG_DEBOUNCE, 16'd0));
        script.push_back(tick_row(1'b1, CHK_EVENT, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b1, CHK_QUIET, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b1, CHK_QUIET, bdh_pkg::EV_PRESSED));
        // Unknown index is dropped; then the widest settings
        script.push_back(reg_row(8'hFF, 16'hFFFF));
        script.push_back(reg_row(bdh_pkg::REG_DEBOUNCE, 16'hFFFF));
        script.push_back(reg_row(bdh_pkg::REG_SHORT_HOLD, 16'hFFFF));
        script.push_back(reg_row(bdh_pkg::REG_LONG_HOLD, 16'hFFFF));
        script.push_back(reg_row(bdh_pkg::REG_PIN_INVERT, 16'hFFFF));
        script.push_back(tick_row(1'b1, CHK_MODEL, bdh_pkg::EV_PRESSED));
        script.push_back(tick_row(1'b0, CHK_MODEL, bdh_pkg::EV_PRESSED));

        foreach (script[i])
        begin
            if (script[i].is_reg)
                write_reg(script[i].idx, script[i].data);
            else
                send_tick(script[i].pin, script[i].chk, script[i].code);
        end

        // Random phases: fresh settings, then mostly clean presses and holds
        // with bounces mixed in; some phases are pure pin noise. Every few
        // phases run at the widest settings, where nothing should happen.
        random_ticks = 0;
        phase = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            extreme = (phase % 9 == 4);
            if (extreme)
            begin
                deb       = 65535;
                short_val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                long_val  = 16'hFFFF;
            end
            else
            begin
                deb       = $urandom_range(0, 5);
                short_val = DATA_W'($urandom_range(0, 30));
                long_val  = DATA_W'($urandom_range(0, 40));
            end
            if (!calm)
            begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end

            write_reg(bdh_pkg::REG_DEBOUNCE, deb[DATA_W-1:0]);
            write_reg(bdh_pkg::REG_SHORT_HOLD, short_val);
            write_reg(bdh_pkg::REG_LONG_HOLD, long_val);
            // upper bits must be dropped
            write_reg(bdh_pkg::REG_PIN_INVERT, DATA_W'($urandom));
            if ($urandom_range(0, 5) == 0)
                write_reg(IDX_W'($urandom_range(NUM_REGS, 255)), DATA_W'($urandom));

            span  = extreme ? 30 : $urandom_range(60, 110);
            noisy = extreme || ($urandom_range(0, 4) == 0);
            level = 1'($urandom_range(0, 1));
            while (span > 0)
            begin
                if (noisy)
                    run = 1;
                else
                begin
                    // Flip the pin and hold it: short runs bounce, long
                    // runs get through the debounce and into the hold events
                    level = ~level;
                    run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, deb + 1)
                                                     : $urandom_range(deb + 1, deb + 50);
                end
                if (run > span)
                    run = span;
                repeat (run)
                    send_tick(noisy ? 1'($urandom_range(0, 1)) : level, CHK_MODEL,
                              bdh_pkg::EV_PRESSED);
                span = span - run;
                random_ticks = random_ticks + run;
            end

            // Drop all idling for the last stretch of the run
            if (random_ticks >= RANDOM_TICKS - CALM_TICKS)
            begin
                calm      = 1'b1;
                gap_pct   = 0;
                stall_pct = 0;
            end
            phase = phase + 1;
        end

        // Drain the remaining events and let the pipeline settle
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (2 * HOLD_OFF) @(posedge clk);

        if (errors == 0)
            $display("PASS button_debounce_hold_detector");
        else
            $display("FAIL button_debounce_hold_detector");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bdh_pkg.sv
rtl/core/bdh_cfg_regs.sv
rtl/core/bdh_tracker.sv
rtl/core/button_debounce_hold_detector.sv
rtl/core/bdh_checker.sv
tb/tb_top.sv
